// File: rtl/ded_pkg.sv
`timescale 1ns / 1ps
// Package for the derivative expiry date unit: request and result structs,
// calendar constants and small lookup functions. No dependencies.
package ded_pkg;

  localparam int unsigned YEAR_IN_W  = 12;
  localparam int unsigned YEAR_W     = 13;
  localparam int unsigned MONTH_W    = 4;
  localparam int unsigned DAY_IN_W   = 5;
  localparam int unsigned DAY_OUT_W  = 4;
  localparam int unsigned AHEAD_W    = 4;
  localparam int unsigned WDAY_W     = 3;

  localparam logic [MONTH_W-1:0] MONTHS_PER_YEAR = 4'd12;
  localparam logic [MONTH_W-1:0] MONTH_JAN       = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB       = 4'd2;

  typedef struct packed {
    logic [YEAR_IN_W-1:0] in_year;
    logic [MONTH_W-1:0]   in_month;
    logic [DAY_IN_W-1:0]  in_day;
    logic                 is_quarterly;
    logic [AHEAD_W-1:0]   periods_ahead;
  } ded_in_t;

  typedef struct packed {
    logic [YEAR_W-1:0]    out_year;
    logic [MONTH_W-1:0]   out_month;
    logic [DAY_OUT_W-1:0] out_day;
  } ded_out_t;

  // Days in the year before the first of month m (1..12), non-leap.
  function automatic logic [8:0] days_before(input logic [MONTH_W-1:0] m);
    logic [8:0] d;
    unique case (m)
      4'd2:    d = 9'd31;
      4'd3:    d = 9'd59;
      4'd4:    d = 9'd90;
      4'd5:    d = 9'd120;
      4'd6:    d = 9'd151;
      4'd7:    d = 9'd181;
      4'd8:    d = 9'd212;
      4'd9:    d = 9'd243;
      4'd10:   d = 9'd273;
      4'd11:   d = 9'd304;
      4'd12:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

  // Second Thursday, given weekday of the 1st (0 = Sunday in this count).
  function automatic logic [DAY_OUT_W-1:0] second_thu(input logic [WDAY_W-1:0] w);
    logic [DAY_OUT_W-1:0] d;
    unique case (w)
      3'd0:    d = 4'd12;
      3'd1:    d = 4'd11;
      3'd2:    d = 4'd10;
      3'd3:    d = 4'd9;
      3'd4:    d = 4'd8;
      3'd5:    d = 4'd14;
      3'd6:    d = 4'd13;
      default: d = 4'd8;
    endcase
    return d;
  endfunction

  // Month rounded up to the quarter end (3, 6, 9, 12); m in 1..12.
  function automatic logic [MONTH_W-1:0] quarter_end(input logic [MONTH_W-1:0] m);
    logic [MONTH_W-1:0] q;
    unique case (m)
      4'd1, 4'd2, 4'd3:    q = 4'd3;
      4'd4, 4'd5, 4'd6:    q = 4'd6;
      4'd7, 4'd8, 4'd9:    q = 4'd9;
      default:             q = 4'd12;
    endcase
    return q;
  endfunction

endpackage

// File: rtl/derivative_expiry_date_unit.sv
`timescale 1ns / 1ps
// Derivative expiry date unit: trade date in, second-Thursday expiry out.
// Depends on ded_pkg and ded_weekday.
//
// Usage:
//   in_valid/in_ready/in_data carry one request: trade year, month, day,
//   quarterly flag and periods ahead. out_valid/out_ready/out_data carry the
//   expiry year, month and day (always 8..14).
//   From accept to out_valid a request passes an input stage, a
//   three-stage weekday pipe for the trade month, a roll stage, a period
//   advance stage, a second weekday pipe and the output register.
//   Throughput is one request per cycle while the receiver does not stall;
//   every stage holds one request and valid bits move with the data.
//   Reset (rst, synchronous) clears all valid bits; payload is not reset.
//   When the receiver stalls with a result waiting, the whole pipe holds and
//   in_ready drops; nothing is lost or repeated. While the output register
//   is empty in_ready stays high.
module derivative_expiry_date_unit (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  ded_pkg::ded_in_t  in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output ded_pkg::ded_out_t out_data
);
  import ded_pkg::*;

  localparam int SIDE1_W = YEAR_W + MONTH_W + DAY_IN_W + 1 + AHEAD_W;
  localparam int SIDE2_W = YEAR_W + MONTH_W;

  logic adv;
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  // input stage: normalize and quarter rounding
  logic               s0_valid;
  logic [YEAR_W-1:0]  s0_year;
  logic [MONTH_W-1:0] s0_month;
  logic [DAY_IN_W-1:0] s0_day;
  logic               s0_qtr;
  logic [AHEAD_W-1:0] s0_ahead;

  logic [YEAR_W-1:0]   n_year;
  logic [MONTH_W-1:0]  n_month;
  logic [MONTH_W-1:0]  c_month;
  logic [DAY_IN_W-1:0] n_day;

  always_comb begin
    n_year = (in_data.in_year == '0) ? 13'd1 : {1'b0, in_data.in_year};
    c_month = in_data.in_month;
    if (c_month == '0) begin
      c_month = MONTH_JAN;
    end
    if (c_month > MONTHS_PER_YEAR) begin
      c_month = MONTHS_PER_YEAR;
    end
    n_month = c_month;
    n_day   = in_data.in_day;
    if (in_data.is_quarterly) begin
      n_month = quarter_end(c_month);
      if (n_month != c_month) begin
        n_day = 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (adv) begin
      s0_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_year  <= n_year;
      s0_month <= n_month;
      s0_day   <= n_day;
      s0_qtr   <= in_data.is_quarterly;
      s0_ahead <= in_data.periods_ahead;
    end
  end

  // weekday of the trade month
  logic               w1_valid;
  logic [WDAY_W-1:0]  w1_wday;
  logic [SIDE1_W-1:0] w1_side;
  logic [YEAR_W-1:0]  w1_year;
  logic [MONTH_W-1:0] w1_month;
  logic [DAY_IN_W-1:0] w1_day;
  logic               w1_qtr;
  logic [AHEAD_W-1:0] w1_ahead;

  ded_weekday #(.SIDE_W(SIDE1_W)) u_wd_trade (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (s0_valid),
    .year      (s0_year),
    .month     (s0_month),
    .side_in   ({s0_year, s0_month, s0_day, s0_qtr, s0_ahead}),
    .out_valid (w1_valid),
    .wday      (w1_wday),
    .side_out  (w1_side)
  );

  assign {w1_year, w1_month, w1_day, w1_qtr, w1_ahead} = w1_side;

  // roll stage: step past this month's expiry, then add periods ahead
  logic              s4_valid;
  logic [YEAR_W-1:0] s4_year;
  logic [5:0]        s4_mtot;

  logic [1:0]        step;
  logic [4:0]        rolled;
  logic [MONTH_W-1:0] r_month;
  logic [YEAR_W-1:0] r_year;
  logic [5:0]        adv_months;
  logic [5:0]        mtot_next;

  always_comb begin
    step   = w1_qtr ? 2'd3 : 2'd1;
    rolled = {1'b0, w1_month};
    r_year = w1_year;
    if ({1'b0, w1_day} > {2'd0, second_thu(w1_wday)}) begin
      rolled = {1'b0, w1_month} + {3'd0, step};
    end
    if (rolled > {1'b0, MONTHS_PER_YEAR}) begin
      rolled = rolled - {1'b0, MONTHS_PER_YEAR};
      r_year = w1_year + 13'd1;
    end
    r_month    = rolled[3:0];
    adv_months = w1_qtr ? ({2'd0, w1_ahead} + {1'b0, w1_ahead, 1'b0}) : {2'd0, w1_ahead};
    mtot_next  = {2'd0, r_month} + adv_months;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else if (adv) begin
      s4_valid <= w1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_year <= r_year;
      s4_mtot <= mtot_next;
    end
  end

  // carry whole years out of the month total; x/12 = (x*43) >> 9 for x < 64
  logic               s5_valid;
  logic [YEAR_W-1:0]  s5_year;
  logic [MONTH_W-1:0] s5_month;

  logic [5:0]  mzero;
  logic [11:0] div_prod;
  logic [2:0]  yadd;
  logic [5:0]  mrem;

  assign mzero    = s4_mtot - 6'd1;
  assign div_prod = {6'd0, mzero} * 12'd43;
  assign yadd     = div_prod[11:9];
  assign mrem     = mzero - 6'({3'd0, yadd} * 6'd12) + 6'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_valid <= 1'b0;
    end else if (adv) begin
      s5_valid <= s4_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s5_year  <= s4_year + {10'd0, yadd};
      s5_month <= mrem[3:0];
    end
  end

  // weekday of the expiry month
  logic               w2_valid;
  logic [WDAY_W-1:0]  w2_wday;
  logic [SIDE2_W-1:0] w2_side;

  ded_weekday #(.SIDE_W(SIDE2_W)) u_wd_expiry (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (s5_valid),
    .year      (s5_year),
    .month     (s5_month),
    .side_in   ({s5_year, s5_month}),
    .out_valid (w2_valid),
    .wday      (w2_wday),
    .side_out  (w2_side)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= w2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data.out_year  <= w2_side[SIDE2_W-1:MONTH_W];
      out_data.out_month <= w2_side[MONTH_W-1:0];
      out_data.out_day   <= second_thu(w2_wday);
    end
  end

endmodule

// File: rtl/ded_weekday.sv
`timescale 1ns / 1ps
// Three-stage pipelined weekday of the first of a month (day count mod 7).
// Depends on ded_pkg. Side data rides along with the valid bit.
module ded_weekday #(
  parameter int SIDE_W = 8
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic                       in_valid,
  input  logic [ded_pkg::YEAR_W-1:0] year,
  input  logic [ded_pkg::MONTH_W-1:0] month,
  input  logic [SIDE_W-1:0]          side_in,
  output logic                       out_valid,
  output logic [ded_pkg::WDAY_W-1:0] wday,
  output logic [SIDE_W-1:0]          side_out
);
  import ded_pkg::*;

  // stage a: p = year-1, quarter-year values and /25 reciprocal products
  logic              a_valid;
  logic [12:0]       a_p;
  logic [10:0]       a_q;
  logic [10:0]       a_yq;
  logic              a_y4;
  logic [20:0]       a_prod_c;
  logic [20:0]       a_prod_y;
  logic [MONTH_W-1:0] a_month;
  logic [SIDE_W-1:0] a_side;

  // stage b: day count sum
  logic              b_valid;
  logic [13:0]       b_s;
  logic [SIDE_W-1:0] b_side;

  // stage c: /7 reciprocal product
  logic              c_valid;
  logic [13:0]       c_s;
  logic [27:0]       c_prod;
  logic [SIDE_W-1:0] c_side;

  logic [12:0] p;
  logic [10:0] q;
  logic [10:0] yq;
  logic [5:0]  cent;
  logic [5:0]  dy;
  logic [10:0] rem_wide;
  logic [4:0]  rem25;
  logic        leap;
  logic        leap_adj;
  logic [13:0] s_next;
  logic [9:0]  quo7;
  logic [13:0] w_wide;

  assign p  = year - 13'd1;
  assign q  = p[12:2];
  assign yq = year[12:2];

  // x/25 = (x*1311) >> 15, exact for x below 1100
  assign cent     = a_prod_c[20:15];
  assign dy       = a_prod_y[20:15];
  assign rem_wide = a_yq - 11'({5'd0, dy} * 11'd25);
  assign rem25    = rem_wide[4:0];
  assign leap     = a_y4 && ((rem25 != 5'd0) || (dy[1:0] == 2'd0));
  assign leap_adj = leap && (a_month > MONTH_FEB);

  // 365 = 1 mod 7, so the year term reduces to p
  assign s_next = {1'b0, a_p} + {3'd0, a_q} - {8'd0, cent} + {10'd0, cent[5:2]}
                + {5'd0, days_before(a_month)} + 14'd1 + {13'd0, leap_adj};

  // x/7 = (x*9363) >> 16, exact for x below 8192
  assign quo7   = c_prod[25:16];
  assign w_wide = c_s - 14'({4'd0, quo7} * 14'd7);
  assign wday   = w_wide[2:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      c_valid <= 1'b0;
    end else if (en) begin
      a_valid <= in_valid;
      b_valid <= a_valid;
      c_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_p      <= p;
      a_q      <= q;
      a_yq     <= yq;
      a_y4     <= (year[1:0] == 2'd0);
      a_prod_c <= {10'd0, q} * 21'd1311;
      a_prod_y <= {10'd0, yq} * 21'd1311;
      a_month  <= month;
      a_side   <= side_in;
      b_s      <= s_next;
      b_side   <= a_side;
      c_s      <= b_s;
      c_prod   <= {14'd0, b_s} * 28'd9363;
      c_side   <= b_side;
    end
  end

  assign out_valid = c_valid;
  assign side_out  = c_side;

endmodule

// File: rtl/ded_checker.sv
`timescale 1ns / 1ps
// Port-level checks for derivative_expiry_date_unit, attached by bind.
// Depends on ded_pkg.
module ded_checker (
  input logic              clk,
  input logic              rst,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input ded_pkg::ded_out_t out_data
);
  import ded_pkg::*;

  // a stalled result holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // expiry day lies in 8..14, the range of a second Thursday
  a_day_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.out_day >= 4'd8) && (out_data.out_day <= 4'd14))
    else $error("expiry day out of range");

  a_month_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.out_month >= MONTH_JAN) &&
                  (out_data.out_month <= MONTHS_PER_YEAR))
    else $error("expiry month out of range");

  // empty output register never blocks a request
  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("request blocked with empty output");

  a_reset_clear: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind derivative_expiry_date_unit ded_checker u_ded_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// File: test/derivative_expiry_date_unit_tb.sv
`timescale 1ns / 1ps
// Testbench for derivative_expiry_date_unit: directed and random trade-date requests,
// each checked against a listed expected value or an in-bench calendar predictor of the second-Thursday expiry.
// Depends on ded_pkg and the RTL of the unit.
module derivative_expiry_date_unit_tb;

  localparam int unsigned N_RANDOM    = 1630;
  localparam int unsigned QUIET_TAIL  = 200;
  localparam int unsigned LONG_HOLD   = 300;
  localparam int unsigned DRAIN_WAIT  = 20;
  localparam int unsigned CYCLE_LIMIT = 400_000;

  typedef struct {
    ded_pkg::ded_in_t  req;
    bit                known;
    ded_pkg::ded_out_t res;
  } table_row_t;

  logic              clk;
  logic              rst;
  logic              in_valid;
  logic              in_ready;
  ded_pkg::ded_in_t  in_data;
  logic              out_valid;
  logic              out_ready;
  ded_pkg::ded_out_t out_data;

  ded_pkg::ded_out_t expiry_q[$];
  table_row_t        stim_table[$];
  int unsigned       cum_days[12] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};

  int unsigned cycles = 0;
  int unsigned mismatches = 0;
  int unsigned accepted;
  int unsigned quarterly_cnt;
  int unsigned results_cnt = 0;
  int unsigned backpressure_cycles = 0;
  int unsigned long_holds = 0;
  int unsigned idle_odds;
  bit          hold_long;

  derivative_expiry_date_unit DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #5 clk = ~clk;

  // Day of month of the second Thursday; day 1 of the count is Monday, Jan 1 of year 1.
  function automatic int unsigned expiry_day_in(int unsigned y, int unsigned m);
    int unsigned p;
    int unsigned n;
    bit          leap;
    p    = y - 1;
    leap = (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
    n    = p * 365 + p / 4 - p / 100 + p / 400 + cum_days[m - 1] + 1;
    if (m > 2 && leap) n++;
    return ((11 - n % 7) % 7) + 8;
  endfunction

  function automatic ded_pkg::ded_out_t expiry_of(ded_pkg::ded_in_t r);
    int unsigned       y;
    int unsigned       m;
    int unsigned       d;
    int unsigned       step;
    ded_pkg::ded_out_t res;
    y    = r.in_year;
    m    = r.in_month;
    d    = r.in_day;
    step = r.is_quarterly ? 3 : 1;
    if (y == 0) y = 1;
    if (m == 0) m = 1;
    if (m > 12) m = 12;
    if (r.is_quarterly) begin
      // off-quarter month: contract starts from the 1st of the quarter month
      if (m % 3 != 0) d = 1;
      m += (12 - m) % 3;
    end
    if (d > expiry_day_in(y, m)) begin
      m += step;
      if (m > 12) begin
        m -= 12;
        y++;
      end
    end
    m += step * r.periods_ahead;
    y += (m - 1) / 12;
    m = (m - 1) % 12 + 1;
    res.out_year  = y[ded_pkg::YEAR_W-1:0];
    res.out_month = m[ded_pkg::MONTH_W-1:0];
    res.out_day   = 4'(expiry_day_in(y, m));
    return res;
  endfunction

  function automatic void add_row(int unsigned y, int unsigned m, int unsigned d, bit q,
                                  int unsigned a, bit known = 0, int unsigned ey = 0,
                                  int unsigned em = 0, int unsigned eday = 0);
    table_row_t row;
    row.req.in_year       = 12'(y);
    row.req.in_month      = 4'(m);
    row.req.in_day        = 5'(d);
    row.req.is_quarterly  = q;
    row.req.periods_ahead = 4'(a);
    row.known             = known;
    row.res.out_year      = 13'(ey);
    row.res.out_month     = 4'(em);
    row.res.out_day       = 4'(eday);
    stim_table = {stim_table, row};
  endfunction

  function automatic ded_pkg::ded_in_t random_request();
    ded_pkg::ded_in_t r;
    if ($urandom_range(0, 19) == 0) begin
      // raw noise: every field over its full bit range
      r = ded_pkg::ded_in_t'($urandom);
    end else begin
      case ($urandom_range(0, 9))
        0:       r.in_year = 12'd1;
        1:       r.in_year = 12'd4095;
        default: r.in_year = 12'($urandom_range(1, 4095));
      endcase
      r.in_month      = 4'($urandom_range(1, 12));
      r.in_day        = $urandom_range(0, 1) ? 5'($urandom_range(1, 31))
                                             : 5'($urandom_range(6, 16));
      r.is_quarterly  = 1'($urandom_range(0, 1));
      r.periods_ahead = $urandom_range(0, 9) < 7 ? 4'($urandom_range(0, 3))
                                                 : 4'($urandom_range(0, 15));
    end
    return r;
  endfunction

  task automatic offer(input ded_pkg::ded_in_t r, input ded_pkg::ded_out_t want);
    int unsigned gap;
    if (idle_odds != 0 && $urandom_range(0, 99) < idle_odds) begin
      in_valid <= 1'b0;
      gap = $urandom_range(1, 19);
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= r;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expiry_q = {expiry_q, want};
    accepted++;
    if (r.is_quarterly) quarterly_cnt++;
  endtask

  // receiver: random stall bursts, plus one long hold-off on request
  initial begin
    out_ready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_long && long_holds == 0) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        long_holds++;
      end else if (idle_odds != 0 && $urandom_range(0, 99) < idle_odds) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycles, expiry_q.size());
      $display("Some tests failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    ded_pkg::ded_out_t want;
    if (!rst && in_valid && !in_ready) backpressure_cycles++;
    if (!rst && out_valid && out_ready) begin
      results_cnt++;
      if (expiry_q.size() == 0) begin
        if (mismatches < 10)
          $display("Unexpected result %0d-%0d-%0d", out_data.out_year, out_data.out_month,
                   out_data.out_day);
        mismatches++;
      end else begin
        want = expiry_q.pop_front();
        if (out_data.out_year !== want.out_year || out_data.out_month !== want.out_month ||
            out_data.out_day !== want.out_day) begin
          if (mismatches < 10)
            $display("Mismatch at result %0d: expected %0d-%0d-%0d, got %0d-%0d-%0d",
                     results_cnt, want.out_year, want.out_month, want.out_day,
                     out_data.out_year, out_data.out_month, out_data.out_day);
          mismatches++;
        end
      end
    end
  end

  initial begin
    ded_pkg::ded_in_t r;
    clk                 = 1'b0;
    rst                 = 1'b1;
    in_valid            = 1'b0;
    in_data             = '0;
    accepted            = 0;
    quarterly_cnt       = 0;
    idle_odds           = 15;
    hold_long           = 0;

    // year, month, day, quarterly, periods ahead [, expected year, month, day]
    add_row(0,    0,  0,  0, 0,  1, 1,    1, 11);  // year and month zero
    add_row(1,    1,  11, 0, 0,  1, 1,    1, 11);  // on expiry day: no roll
    add_row(1,    1,  12, 0, 0);                   // day after expiry
    add_row(2024, 1,  12, 0, 0,  1, 2024, 2, 8);
    add_row(2024, 1,  31, 1, 0,  1, 2024, 3, 14);  // off-quarter month, day reset
    add_row(4095, 12, 31, 1, 15);                  // largest output year
    add_row(4095, 15, 31, 0, 15);                  // month above twelve
    add_row(4095, 13, 0,  1, 0);
    add_row(2000, 14, 14, 0, 1);
    add_row(2000, 2,  29, 0, 0);                   // leap February
    add_row(1900, 3,  31, 1, 3);                   // century, not leap
    add_row(2100, 12, 31, 0, 0);                   // roll into next year
    add_row(2023, 6,  31, 1, 0);
    add_row(2023, 6,  1,  1, 0);
    add_row(2023, 5,  31, 1, 2);
    add_row(400,  11, 30, 1, 15);
    add_row(1,    12, 31, 1, 15);
    add_row(4095, 0,  31, 0, 7);
    add_row(2048, 9,  8,  1, 4);
    add_row(3000, 7,  14, 0, 15);
    add_row(2047, 10, 0,  1, 11);

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (stim_table[i])
      offer(stim_table[i].req,
            stim_table[i].known ? stim_table[i].res : expiry_of(stim_table[i].req));

    for (int i = 0; i < N_RANDOM; i++) begin
      // vary idling density in phases, including stretches with none
      if (i % 100 == 0) begin
        case ($urandom_range(0, 2))
          0:       idle_odds = 0;
          1:       idle_odds = 10;
          default: idle_odds = 40;
        endcase
      end
      if (i >= N_RANDOM - QUIET_TAIL) idle_odds = 0;
      if (i == 300) hold_long = 1;
      r = random_request();
      offer(r, expiry_of(r));
    end
    in_valid <= 1'b0;

    while (expiry_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("Checked %0d of %0d expiry requests (%0d directed, %0d quarterly).",
             results_cnt, accepted, stim_table.size(), quarterly_cnt);
    $display("Input stalled by a full pipe for %0d cycles; %0d long output hold-off(s).",
             backpressure_cycles, long_holds);
    if (mismatches == 0 && expiry_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// File: derivative_expiry_date_unit.f
rtl/ded_pkg.sv
rtl/ded_weekday.sv
rtl/derivative_expiry_date_unit.sv
rtl/ded_checker.sv
test/derivative_expiry_date_unit_tb.sv
